@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the triangle normal unit.
// No dependencies; files that assert take this header by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TUN_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: assertion failed");
`define TUN_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: implication failed");
`else
`define TUN_ASSERT(label, clk, rstn, prop)
`define TUN_ASSERT_IMPLY(label, clk, rstn, ante, cons)
`endif
`endif

@@ hw/rtl/tun_pkg.sv @@
// Shared constants and types of the triangle normal pipeline.
// No dependencies.
package tun_pkg;

    localparam int MAG_W   = 23;             // normalized magnitude bits
    localparam int FRAC_W  = 15;             // Q1.15 fraction bits
    localparam int OUT_W   = 16;
    localparam int SUM_W   = 2 * MAG_W + 2;  // sum of three squares
    localparam int ROOT_W  = SUM_W / 2;
    localparam int NUM_W   = MAG_W + FRAC_W + 1;
    localparam int REM_W   = NUM_W + 1;
    localparam int QUO_W   = FRAC_W + 2;

    localparam int CROSS_LAT = 3;
    localparam int NORM_LAT  = 3;
    localparam int SQRT_LAT  = 2 + ROOT_W;
    localparam int DIV_LAT   = 1 + QUO_W;
    localparam int PIPE_LAT  = CROSS_LAT + NORM_LAT + SQRT_LAT + DIV_LAT + 1;

    localparam logic [QUO_W-1:0] Q_MAX = QUO_W'((1 << FRAC_W) - 1);

    typedef struct packed {
        logic neg;
        logic degen;
    } lane_ctl_t;

endpackage

@@ hw/rtl/tun_cross.sv @@
// Edge vectors, six partial products and the exact cross product.
// Depends on nothing but its parameter; three register stages.
module tun_cross #(
    parameter int W = 24
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic signed [W-1:0]   a [3],
    input  logic signed [W-1:0]   b [3],
    input  logic signed [W-1:0]   c [3],
    input  logic                  flip,
    output logic signed [2*W+2:0] cr [3]
);

    localparam int D = W + 1;
    localparam int P = 2 * D;

    logic signed [D-1:0]   u_reg [3];
    logic signed [D-1:0]   w_reg [3];
    logic signed [D-1:0]   u_next [3];
    logic signed [D-1:0]   w_next [3];
    logic signed [P-1:0]   p_reg [6];
    logic signed [P-1:0]   p_next [6];
    logic signed [P:0]     cr_reg [3];
    logic signed [P:0]     cr_next [3];

    always_comb begin
        logic [D-1:0] d1;
        logic [D-1:0] d2;
        for (int i = 0; i < 3; i++) begin
            d1 = {a[i][W-1], a[i]} - {b[i][W-1], b[i]};
            d2 = {a[i][W-1], a[i]} - {c[i][W-1], c[i]};
            u_next[i] = flip ? d2 : d1;
            w_next[i] = flip ? d1 : d2;
        end
    end

    always_comb begin
        p_next[0] = P'(u_reg[1]) * P'(w_reg[2]);
        p_next[1] = P'(u_reg[2]) * P'(w_reg[1]);
        p_next[2] = P'(u_reg[2]) * P'(w_reg[0]);
        p_next[3] = P'(u_reg[0]) * P'(w_reg[2]);
        p_next[4] = P'(u_reg[0]) * P'(w_reg[1]);
        p_next[5] = P'(u_reg[1]) * P'(w_reg[0]);
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cr_next[i] = {p_reg[2*i][P-1], p_reg[2*i]} - {p_reg[2*i+1][P-1], p_reg[2*i+1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg  <= u_next;
            w_reg  <= w_next;
            p_reg  <= p_next;
            cr_reg <= cr_next;
        end
    end

    assign cr = cr_reg;

endmodule

@@ hw/rtl/tun_norm.sv @@
// Sign/magnitude split, leading-one search and block shift to 23 bits.
// Uses tun_pkg; three register stages.
module tun_norm #(
    parameter int X = 51
) (
    input  logic                       aclk,
    input  logic                       en,
    input  logic signed [X-1:0]        cr [3],
    output logic [tun_pkg::MAG_W-1:0]  mag [3],
    output logic [2:0]                 neg,
    output logic                       degen
);

    localparam int MW   = tun_pkg::MAG_W;
    localparam int BL_W = $clog2(X + 1);
    localparam int EW   = X + MW;

    logic [X-1:0]    cm_a_reg [3];
    logic [X-1:0]    cm_a_next [3];
    logic [X-1:0]    or_reg;
    logic [2:0]      neg_a_reg;
    logic [X-1:0]    cm_b_reg [3];
    logic [BL_W-1:0] bl_reg;
    logic [BL_W-1:0] bl_next;
    logic [2:0]      neg_b_reg;
    logic [MW-1:0]   mag_reg [3];
    logic [MW-1:0]   mag_next [3];
    logic [2:0]      neg_c_reg;
    logic            degen_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cm_a_next[i] = cr[i][X-1] ? (~cr[i] + X'(1)) : cr[i];
        end
    end

    // bit length of the largest magnitude equals that of the OR
    always_comb begin
        bl_next = '0;
        for (int i = 0; i < X; i++) begin
            if (or_reg[i]) begin
                bl_next = BL_W'(i + 1);
            end
        end
    end

    always_comb begin
        logic [EW-1:0] ext;
        for (int i = 0; i < 3; i++) begin
            ext = {{MW{1'b0}}, cm_b_reg[i]};
            if (int'(bl_reg) > MW) begin
                ext = ext >> (int'(bl_reg) - MW);
            end else begin
                ext = ext << (MW - int'(bl_reg));
            end
            mag_next[i] = ext[MW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cm_a_reg  <= cm_a_next;
            or_reg    <= cm_a_next[0] | cm_a_next[1] | cm_a_next[2];
            neg_a_reg <= {cr[2][X-1], cr[1][X-1], cr[0][X-1]};
            cm_b_reg  <= cm_a_reg;
            bl_reg    <= bl_next;
            neg_b_reg <= neg_a_reg;
            mag_reg   <= mag_next;
            neg_c_reg <= neg_b_reg;
            degen_reg <= (bl_reg == '0);
        end
    end

    assign mag   = mag_reg;
    assign neg   = neg_c_reg;
    assign degen = degen_reg;

endmodule

@@ hw/rtl/tun_isqrt.sv @@
// Squares, their sum and a one-bit-per-stage integer square root.
// Uses tun_pkg; carries magnitudes and a side vector alongside.
module tun_isqrt #(
    parameter int SIDE_W = 6
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [3*tun_pkg::MAG_W-1:0]       mag,
    input  logic [SIDE_W-1:0]                 side,
    output logic [tun_pkg::ROOT_W-1:0]        root,
    output logic [3*tun_pkg::MAG_W-1:0]       mag_o,
    output logic [SIDE_W-1:0]                 side_o
);

    localparam int MW  = tun_pkg::MAG_W;
    localparam int SW  = tun_pkg::SUM_W;
    localparam int RW  = tun_pkg::ROOT_W;
    localparam int LAT = tun_pkg::SQRT_LAT;
    localparam int TW  = SW + 2;
    localparam int QW  = 2 * MW;

    logic [QW-1:0]     sq_reg [3];
    logic [SW-1:0]     rem_reg [RW+1];
    logic [RW-1:0]     root_reg [RW+1];
    logic [3*MW-1:0]   mag_pipe [LAT];
    logic [SIDE_W-1:0] side_pipe [LAT];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= QW'(mag[i*MW +: MW]) * QW'(mag[i*MW +: MW]);
            end
            rem_reg[0]  <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
            root_reg[0] <= '0;
            mag_pipe[0]  <= mag;
            side_pipe[0] <= side;
            for (int k = 1; k < LAT; k++) begin
                mag_pipe[k]  <= mag_pipe[k-1];
                side_pipe[k] <= side_pipe[k-1];
            end
        end
    end

    for (genvar k = 0; k < RW; k++) begin : g_step
        localparam int BI = RW - 1 - k;
        logic [TW-1:0] trial;
        logic          fits;
        assign trial = (TW'(root_reg[k]) << (BI + 1)) | (TW'(1) << (2 * BI));
        assign fits  = (TW'(rem_reg[k]) >= trial);
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1]  <= fits ? SW'(TW'(rem_reg[k]) - trial) : rem_reg[k];
                root_reg[k+1] <= fits ? (root_reg[k] | (RW'(1) << BI)) : root_reg[k];
            end
        end
    end

    assign root   = root_reg[RW];
    assign mag_o  = mag_pipe[LAT-1];
    assign side_o = side_pipe[LAT-1];

endmodule

@@ hw/rtl/tun_div.sv @@
// One lane of rounded restoring division: (m * 2^15 + len/2) / len.
// Uses tun_pkg; one setup stage, then one quotient bit per stage.
module tun_div (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [tun_pkg::MAG_W-1:0]     m,
    input  logic [tun_pkg::ROOT_W-1:0]    len,
    input  tun_pkg::lane_ctl_t            ctl,
    output logic [tun_pkg::QUO_W-1:0]     q,
    output tun_pkg::lane_ctl_t            ctl_o
);

    localparam int RW = tun_pkg::ROOT_W;
    localparam int QW = tun_pkg::QUO_W;
    localparam int EW = tun_pkg::REM_W;

    logic [EW-1:0]      rem_reg [QW+1];
    logic [RW-1:0]      len_reg [QW+1];
    logic [QW-1:0]      q_reg [QW+1];
    tun_pkg::lane_ctl_t ctl_reg [QW+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= (EW'(m) << tun_pkg::FRAC_W) + EW'(len >> 1);
            len_reg[0] <= len;
            q_reg[0]   <= '0;
            ctl_reg[0] <= ctl;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        localparam int BI = QW - 1 - k;
        logic [EW-1:0] dvs;
        logic          fits;
        assign dvs  = EW'(len_reg[k]) << BI;
        assign fits = (rem_reg[k] >= dvs);
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= fits ? (rem_reg[k] - dvs) : rem_reg[k];
                q_reg[k+1]   <= fits ? (q_reg[k] | (QW'(1) << BI)) : q_reg[k];
                len_reg[k+1] <= len_reg[k];
                ctl_reg[k+1] <= ctl_reg[k];
            end
        end
    end

    assign q     = q_reg[QW];
    assign ctl_o = ctl_reg[QW];

endmodule

@@ hw/rtl/triangle_unit_normal.sv @@
// Top level of the triangle unit-normal pipeline.
// Uses tun_pkg, tun_cross, tun_norm, tun_isqrt, tun_div and assert_macros.svh.
//
//  channel | direction | handshake          | word
//  s_      | in        | s_valid / s_ready  | three vertices + flip
//  m_      | out       | m_valid / m_ready  | nx, ny, nz (Q1.15) + degenerate
//
// One word enters per cycle while the pipe is not held. Words pass through the
// cross product, normalization, square root and divider stages in that order.
// All stages move on one enable: the pipe advances while the output register
// is empty or being taken. When m_valid is high and m_ready low, the whole pipe
// holds and s_ready is low. Reset (aresetn low, synchronous) clears the valid
// bits only; data registers carry no reset.
`include "assert_macros.svh"

module triangle_unit_normal #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_ax,
    input  logic signed [COORD_WIDTH-1:0] s_ay,
    input  logic signed [COORD_WIDTH-1:0] s_az,
    input  logic signed [COORD_WIDTH-1:0] s_bx,
    input  logic signed [COORD_WIDTH-1:0] s_by_coord,
    input  logic signed [COORD_WIDTH-1:0] s_bz,
    input  logic signed [COORD_WIDTH-1:0] s_cx,
    input  logic signed [COORD_WIDTH-1:0] s_cy,
    input  logic signed [COORD_WIDTH-1:0] s_cz,
    input  logic                          s_flip,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [15:0]            m_nx,
    output logic signed [15:0]            m_ny,
    output logic signed [15:0]            m_nz,
    output logic                          m_degenerate
);

    localparam int W    = COORD_WIDTH;
    localparam int X    = 2 * W + 3;
    localparam int MW   = tun_pkg::MAG_W;
    localparam int QW   = tun_pkg::QUO_W;
    localparam int OW   = tun_pkg::OUT_W;
    localparam int LAT  = tun_pkg::PIPE_LAT;
    localparam int CW   = $bits(tun_pkg::lane_ctl_t);

    logic en;

    // valid bits travel beside the data; the last one is m_valid
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;

    logic signed [W-1:0] a [3];
    logic signed [W-1:0] b [3];
    logic signed [W-1:0] c [3];
    logic signed [X-1:0] cr [3];
    logic [MW-1:0]       mag [3];
    logic [2:0]          neg;
    logic                degen;

    logic [3*MW-1:0]          mag_in;
    logic [3*CW-1:0]          side_in;
    logic [tun_pkg::ROOT_W-1:0] root;
    logic [3*MW-1:0]          mag_s;
    logic [3*CW-1:0]          side_s;
    logic [QW-1:0]            q [3];
    tun_pkg::lane_ctl_t       ctl_q [3];

    logic signed [OW-1:0] n_reg [3];
    logic signed [OW-1:0] n_next [3];
    logic                 degen_reg;

    assign en      = !vld_reg[LAT-1] || m_ready;
    assign s_ready = en;

    assign a = '{s_ax, s_ay, s_az};
    assign b = '{s_bx, s_by_coord, s_bz};
    assign c = '{s_cx, s_cy, s_cz};

    tun_cross #(.W(W)) u_cross (
        .aclk (aclk),
        .en   (en),
        .a    (a),
        .b    (b),
        .c    (c),
        .flip (s_flip),
        .cr   (cr)
    );

    tun_norm #(.X(X)) u_norm (
        .aclk  (aclk),
        .en    (en),
        .cr    (cr),
        .mag   (mag),
        .neg   (neg),
        .degen (degen)
    );

    always_comb begin
        tun_pkg::lane_ctl_t lc;
        for (int i = 0; i < 3; i++) begin
            mag_in[i*MW +: MW] = mag[i];
            lc.neg   = neg[i];
            lc.degen = degen;
            side_in[i*CW +: CW] = lc;
        end
    end

    tun_isqrt #(.SIDE_W(3 * CW)) u_isqrt (
        .aclk   (aclk),
        .en     (en),
        .mag    (mag_in),
        .side   (side_in),
        .root   (root),
        .mag_o  (mag_s),
        .side_o (side_s)
    );

    for (genvar i = 0; i < 3; i++) begin : g_lane
        tun_div u_div (
            .aclk  (aclk),
            .en    (en),
            .m     (mag_s[i*MW +: MW]),
            .len   (root),
            .ctl   (tun_pkg::lane_ctl_t'(side_s[i*CW +: CW])),
            .q     (q[i]),
            .ctl_o (ctl_q[i])
        );
    end

    // saturate to 32767, apply sign, zero the normal of a degenerate triangle
    always_comb begin
        logic [QW-1:0] qs;
        for (int i = 0; i < 3; i++) begin
            qs = (q[i] > tun_pkg::Q_MAX) ? tun_pkg::Q_MAX : q[i];
            if (ctl_q[i].degen) begin
                n_next[i] = '0;
            end else if (ctl_q[i].neg) begin
                n_next[i] = -OW'(qs);
            end else begin
                n_next[i] = OW'(qs);
            end
        end
    end

    assign vld_next = {vld_reg[LAT-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg     <= n_next;
            degen_reg <= ctl_q[0].degen;
        end
    end

    assign m_valid      = vld_reg[LAT-1];
    assign m_nx         = n_reg[0];
    assign m_ny         = n_reg[1];
    assign m_nz         = n_reg[2];
    assign m_degenerate = degen_reg;

    // degenerate word carries a zero normal
    `TUN_ASSERT_IMPLY(a_degen_zero, aclk, aresetn, m_valid && m_degenerate, m_nx == 0 && m_ny == 0 && m_nz == 0)
    // a real normal is never all zero
    `TUN_ASSERT_IMPLY(a_nonzero, aclk, aresetn, m_valid && !m_degenerate, m_nx != 0 || m_ny != 0 || m_nz != 0)
    // saturation keeps the output symmetric
    `TUN_ASSERT_IMPLY(a_symmetric, aclk, aresetn, m_valid, m_nx != -16'sd32768 && m_ny != -16'sd32768 && m_nz != -16'sd32768)
    // a held output freezes the whole pipe
    `TUN_ASSERT(a_hold, aclk, aresetn, (m_valid && !m_ready) |=> $stable(vld_reg))

endmodule

@@ tb/triangle_unit_normal_checker.sv @@
// Checker for the triangle normal unit: watches both channels, predicts each normal.
// Depends on nothing beyond the port widths of triangle_unit_normal.
module triangle_unit_normal_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [23:0] s_ax, s_ay, s_az,
    input  logic signed [23:0] s_bx, s_by_coord, s_bz,
    input  logic signed [23:0] s_cx, s_cy, s_cz,
    input  logic               s_flip,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [15:0] m_nx, m_ny, m_nz,
    input  logic               m_degenerate,
    output int                 errors,
    output int                 pending
);

    typedef struct packed {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic               degen;
    } normal_t;

    normal_t normals_due[$];

    function automatic int bit_length(input logic [63:0] v);
        int n;
        n = 0;
        for (int i = 0; i < 64; i++)
            if (v[i]) n = i + 1;
        return n;
    endfunction

    function automatic logic [63:0] floor_root(input logic [63:0] v);
        logic [63:0] r, t;
        r = 0;
        for (int i = 31; i >= 0; i--) begin
            t = r | (64'd1 << i);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    function automatic normal_t unit_normal(
        input logic signed [23:0] a[3], input logic signed [23:0] b[3],
        input logic signed [23:0] c[3], input logic fl);
        logic signed [63:0] u[3], w[3], cr[3];
        logic [63:0] mag[3], sum, root, q;
        logic neg[3];
        int maxlen;
        normal_t n;
        for (int i = 0; i < 3; i++) begin
            u[i] = fl ? 64'(a[i]) - 64'(c[i]) : 64'(a[i]) - 64'(b[i]);
            w[i] = fl ? 64'(a[i]) - 64'(b[i]) : 64'(a[i]) - 64'(c[i]);
        end
        cr[0] = u[1] * w[2] - u[2] * w[1];
        cr[1] = u[2] * w[0] - u[0] * w[2];
        cr[2] = u[0] * w[1] - u[1] * w[0];
        maxlen = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = cr[i] < 0;
            mag[i] = neg[i] ? -cr[i] : cr[i];
            if (bit_length(mag[i]) > maxlen) maxlen = bit_length(mag[i]);
        end
        n = '0;
        if (maxlen == 0) begin
            n.degen = 1'b1;
            return n;
        end
        // common shift puts the largest magnitude at 23 bits
        for (int i = 0; i < 3; i++)
            mag[i] = maxlen > 23 ? mag[i] >> (maxlen - 23) : mag[i] << (23 - maxlen);
        sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        root = floor_root(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << 15) + (root >> 1)) / root;
            if (q > 64'd32767) q = 64'd32767;
            q = neg[i] ? -q : q;
            if (i == 0) n.nx = q[15:0];
            else if (i == 1) n.ny = q[15:0];
            else n.nz = q[15:0];
        end
        return n;
    endfunction

    assign pending = normals_due.size();

    initial errors = 0;

    always @(posedge aclk) begin
        normal_t exp_n;
        logic signed [23:0] a[3], b[3], c[3];
        if (aresetn) begin
            if (s_valid && s_ready) begin
                a = '{s_ax, s_ay, s_az};
                b = '{s_bx, s_by_coord, s_bz};
                c = '{s_cx, s_cy, s_cz};
                normals_due.push_back(unit_normal(a, b, c, s_flip));
            end
            if (m_valid && m_ready) begin
                if (normals_due.size() == 0) begin
                    $display("%0t: unexpected word nx=%0d ny=%0d nz=%0d degenerate=%0b",
                             $time, m_nx, m_ny, m_nz, m_degenerate);
                    errors++;
                end else begin
                    exp_n = normals_due.pop_front();
                    if (m_nx !== exp_n.nx) begin
                        $display("%0t: nx expected %0d actual %0d", $time, exp_n.nx, m_nx);
                        errors++;
                    end
                    if (m_ny !== exp_n.ny) begin
                        $display("%0t: ny expected %0d actual %0d", $time, exp_n.ny, m_ny);
                        errors++;
                    end
                    if (m_nz !== exp_n.nz) begin
                        $display("%0t: nz expected %0d actual %0d", $time, exp_n.nz, m_nz);
                        errors++;
                    end
                    if (m_degenerate !== exp_n.degen) begin
                        $display("%0t: degenerate expected %0b actual %0b",
                                 $time, exp_n.degen, m_degenerate);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

@@ tb/tb.sv @@
// Testbench top for triangle_unit_normal: stimulus, output stalls, watchdog, verdict.
// Depends on triangle_unit_normal and triangle_unit_normal_checker.
module tb;

    localparam int N_RANDOM  = 1300;
    localparam int IDLE_MAX  = 3000;   // cycles without any handshake
    localparam int DRAIN_CYC = 80;     // pipe is 51 deep

    typedef logic signed [23:0] coord_t;

    logic   aclk = 1'b0;
    logic   aresetn = 1'b0;
    logic   s_valid = 1'b0;
    logic   s_ready;
    coord_t s_ax = '0, s_ay = '0, s_az = '0;
    coord_t s_bx = '0, s_by_coord = '0, s_bz = '0;
    coord_t s_cx = '0, s_cy = '0, s_cz = '0;
    logic   s_flip = 1'b0;
    logic   m_valid;
    logic   m_ready = 1'b0;
    logic signed [15:0] m_nx, m_ny, m_nz;
    logic   m_degenerate;
    int     errors, pending;
    int     burst_left = 1;
    int     idle_cycles = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    triangle_unit_normal dut (.*);

    triangle_unit_normal_checker chk (.*);

    // Receiver stalls: the mode rotates between always-ready,
    // coin flip, and a periodic pattern with a long stall.
    always @(posedge aclk) begin
        int phase;
        phase = int'(($time / 128) % 3);
        if (!aresetn) m_ready <= 1'b0;
        else if (phase == 0) m_ready <= 1'b1;
        else if (phase == 1) m_ready <= 1'($urandom_range(0, 1));
        else m_ready <= (($time / 2) % 23) > 6;
    end

    // Watchdog: nothing moved for too long means the pipe is stuck.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_MAX) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Offers one triangle and holds it until taken. Ends a burst with a gap,
    // so valid never drops and rises in one step.
    task automatic send_tri(input coord_t p[9], input logic fl);
        logic took;
        s_ax <= p[0]; s_ay <= p[1]; s_az <= p[2];
        s_bx <= p[3]; s_by_coord <= p[4]; s_bz <= p[5];
        s_cx <= p[6]; s_cy <= p[7]; s_cz <= p[8];
        s_flip <= fl;
        s_valid <= 1'b1;
        do begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end while (!took);
        burst_left--;
        if (burst_left <= 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            // mostly short bursts, some long stretches with no gaps
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end
    endtask

    function automatic coord_t small_coord();
        return coord_t'(int'($urandom_range(0, 400)) - 200);
    endfunction

    initial begin
        coord_t p[9];
        coord_t d[3];
        int k, kind;
        localparam coord_t CMAX = 24'sh7fffff;
        localparam coord_t CMIN = -24'sh800000;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: all zero (coincident vertices, degenerate)
        p = '{default: '0};
        send_tri(p, 1'b0);
        // right triangle in the xy plane: normal exactly +z, then -z with flip
        p = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
        send_tri(p, 1'b0);
        send_tri(p, 1'b1);
        // same along the other axes
        p = '{0, 0, 0, 0, 1, 0, 0, 0, 1};
        send_tri(p, 1'b0);
        p = '{0, 0, 0, 0, 0, 1, 1, 0, 0};
        send_tri(p, 1'b1);
        // extreme coordinates: largest differences, largest cross product
        p = '{CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX};
        send_tri(p, 1'b0);
        send_tri(p, 1'b1);
        p = '{CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN};
        send_tri(p, 1'b0);
        p = '{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN};
        send_tri(p, 1'b1);
        p = '{CMIN, CMAX, 0, CMAX, CMIN, CMAX, 0, CMIN, CMIN};
        send_tri(p, 1'b0);
        // collinear points with a large span (degenerate)
        p = '{CMIN, CMIN, CMIN, 0, 0, 0, CMAX, CMAX, CMAX};
        send_tri(p, 1'b0);
        p = '{-3, -3, -3, 0, 0, 0, 3, 3, 3};
        send_tri(p, 1'b1);
        // two vertices equal (degenerate)
        p = '{5, -7, 9, 5, -7, 9, 100, 200, -300};
        send_tri(p, 1'b0);
        // tiny cross product, needs left shift
        p = '{0, 0, 0, 1, 1, 0, 1, 2, 0};
        send_tri(p, 1'b0);
        p = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
        send_tri(p, 1'b0);
        send_tri(p, 1'b1);
        // near-axis normal with tiny tilt, rounding near full scale
        p = '{0, 0, 0, CMAX, 0, 1, 0, CMAX, 0};
        send_tri(p, 1'b0);
        p = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};
        send_tri(p, 1'b1);

        // random: full range, small values, and degenerate shapes
        for (int n = 0; n < N_RANDOM; n++) begin
            kind = $urandom_range(0, 9);
            if (kind < 5) begin
                foreach (p[i]) p[i] = coord_t'($urandom);
            end else if (kind < 8) begin
                foreach (p[i]) p[i] = small_coord();
                if (kind == 7) p[0] = coord_t'($urandom);
            end else begin
                // c = a + k*(b - a): collinear, or coincident when k is 0
                foreach (d[i]) d[i] = small_coord();
                k = int'($urandom_range(0, 6)) - 3;
                for (int i = 0; i < 3; i++) begin
                    p[i] = coord_t'($urandom);
                    p[3 + i] = p[i] + d[i];
                    p[6 + i] = p[i] + coord_t'(k) * d[i];
                end
            end
            send_tri(p, 1'($urandom_range(0, 1)));
        end
        s_valid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
